@@ rtl/core/lse_pkg.sv @@
// ----------------------------------------------------------------------------
// LSB stego package
// Shared types and constants of the LSB steganography embed/extract block.
// ----------------------------------------------------------------------------
package lse_pkg;

  // Field widths of the item interfaces and of the configuration port.
  localparam int ADDR_FIELD_W = 12;
  localparam int DATA_W       = 64;
  localparam int DEPTH_W      = 4;
  localparam int LIM_W        = 13;
  localparam int CUR_W        = LIM_W + 1;
  localparam int CFG_W        = 13;
  localparam int REG_IDX_W    = 2;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_DEPTH_SETTING = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ALPHA_PRESENT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_BYTES   = 2'd2;

  typedef enum logic [2:0] {
    CMD_LOAD         = 3'd0,
    CMD_READ         = 3'd1,
    CMD_BEGIN        = 3'd2,
    CMD_EMBED_BYTE   = 3'd3,
    CMD_EMBED_WORD   = 3'd4,
    CMD_EXTRACT_BYTE = 3'd5,
    CMD_EXTRACT_WORD = 3'd6
  } cmd_e;

  typedef struct packed {
    cmd_e                    cmd;
    logic [ADDR_FIELD_W-1:0] address;
    logic [DATA_W-1:0]       payload;
  } req_item_t;

  typedef struct packed {
    logic [DATA_W-1:0]  result_data;
    logic               complete;
    logic [DEPTH_W-1:0] active_depth;
  } rsp_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RDWAIT,
    S_XFER,
    S_FINISH
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic load_wr;
    logic begin_set;
    logic begin_detect;
    logic read_capture;
    logic xfer_init;
    logic xfer_step;
    logic fin;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_e cmd;
    logic begin_direct;
    logic xfer_go;
    logic xfer_go_next;
  } dp_status_t;

endpackage

@@ rtl/core/lsb_stego_embed_extract_top.sv @@
// ----------------------------------------------------------------------------
// LSB steganography embed/extract top level
// Hides payload bits in the low bits of a stored cover image and reads them back.
// ----------------------------------------------------------------------------
// Usage: a request item (cmd, address, payload) enters on req_valid/req_stall
// and produces exactly one response item (result_data, complete, active_depth)
// on rsp_valid/rsp_stall. An item is taken at a clock edge with valid high and
// stall low. The block works on one item at a time: req_stall is high from the
// cycle after an item is taken until its result has been loaded into the
// response register. A waiting response does not block the next request.
// From acceptance to a valid response, load and an unknown command pass through
// decode and finish, read and begin with depth detection add a store read step,
// begin with a given depth passes through decode and finish only, and embed and
// extract add the transfer loop over the cover bytes touched (the loop state is
// entered even when nothing can be touched). The loop does one read-modify-write
// of the byte store per cycle. The next item is taken the cycle after a result is
// loaded. If the receiver stalls, the response holds and the block waits in its
// last step before loading the next one. Reset clears configuration, cursor,
// session depth and session limit registers; the byte store contents are
// undefined until loaded.
// Configuration writes are taken at once and belong to idle periods.
// ----------------------------------------------------------------------------
module lsb_stego_embed_extract_top #(
  parameter int IMG_BYTES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lse_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [lse_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  lse_pkg::req_item_t            req_item,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output lse_pkg::rsp_item_t            rsp_item
);

  import lse_pkg::*;

  // Control/status between the sequencer and the datapath.
  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  // The controller steps through decode, store read and the per-byte loop.
  lse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .status   (dp_status),
    .cmd      (ctrl_cmd)
  );

  // The datapath holds the store, the session and the response register.
  lse_dp #(
    .IMG_BYTES(IMG_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req_item (req_item),
    .cmd      (ctrl_cmd),
    .status   (dp_status),
    .rsp_item (rsp_item)
  );

endmodule

@@ rtl/core/lse_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module lse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/lse_ctrl.sv @@
// ----------------------------------------------------------------------------
// LSB stego controller
// Sequences one item at a time through the datapath and owns the result valid.
// ----------------------------------------------------------------------------
module lse_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  input  lse_pkg::dp_status_t status,
  output lse_pkg::ctrl_cmd_t  cmd
);

  import lse_pkg::*;

  ctrl_state_e state;
  ctrl_state_e state_next;
  logic        slot_free;

  assign slot_free = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.fin) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status.cmd)
          CMD_READ: begin
            state_next = S_RDWAIT;
          end
          CMD_BEGIN: begin
            state_next = status.begin_direct ? S_FINISH : S_RDWAIT;
          end
          CMD_EMBED_BYTE, CMD_EMBED_WORD, CMD_EXTRACT_BYTE, CMD_EXTRACT_WORD: begin
            state_next = S_XFER;
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_RDWAIT: begin
        state_next = S_FINISH;
      end
      S_XFER: begin
        if (!status.xfer_go || !status.xfer_go_next) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Commands.
  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.capture = req_valid;
      end
      S_DECODE: begin
        case (status.cmd)
          CMD_LOAD: begin
            cmd.load_wr = 1'b1;
          end
          CMD_BEGIN: begin
            cmd.begin_set = status.begin_direct;
          end
          CMD_EMBED_BYTE, CMD_EMBED_WORD, CMD_EXTRACT_BYTE, CMD_EXTRACT_WORD: begin
            cmd.xfer_init = 1'b1;
          end
          default: begin
            cmd = '0;
          end
        endcase
      end
      S_RDWAIT: begin
        if (status.cmd == CMD_BEGIN) begin
          cmd.begin_detect = 1'b1;
        end else begin
          cmd.read_capture = 1'b1;
        end
      end
      S_XFER: begin
        cmd.xfer_step = status.xfer_go;
      end
      S_FINISH: begin
        cmd.fin = slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_to_decode: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == S_DECODE))
    else $error("accepted item did not move to decode");

  a_fin_needs_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> !(rsp_valid && rsp_stall))
    else $error("result loaded over a stalled result");

  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_FINISH))
    else $error("result valid rose outside finish");

  a_xfer_entry: assert property (@(posedge clk) disable iff (rst)
    (state == S_XFER) |-> ($past(state) == S_DECODE || $past(state) == S_XFER))
    else $error("transfer entered from wrong state");
`endif

endmodule

@@ rtl/core/lse_dp.sv @@
// ----------------------------------------------------------------------------
// LSB stego datapath
// Cover byte store, configuration, session and cursor registers, bit packing.
// ----------------------------------------------------------------------------
module lse_dp #(
  parameter int IMG_BYTES = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lse_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [lse_pkg::CFG_W-1:0]      cfg_data,
  input  lse_pkg::req_item_t             req_item,
  input  lse_pkg::ctrl_cmd_t             cmd,
  output lse_pkg::dp_status_t            status,
  output lse_pkg::rsp_item_t             rsp_item
);

  import lse_pkg::*;

  localparam int AW = $clog2(IMG_BYTES);

  function automatic logic [7:0] ones_mask(input logic [3:0] k);
    logic [8:0] w;
    w = (9'd1 << k) - 9'd1;
    return w[7:0];
  endfunction

  // Configuration registers.
  logic [DEPTH_W-1:0] depth_setting;
  logic               alpha_present;
  logic [LIM_W-1:0]   image_bytes;

  // Session state.
  logic [CUR_W-1:0]   cursor_byte;
  logic [2:0]         cursor_bit;
  logic [DEPTH_W-1:0] session_depth;
  logic [LIM_W-1:0]   session_limit;
  logic               begin_ok;

  // Item working registers.
  req_item_t          item;
  logic [6:0]         remaining;
  logic [DATA_W-1:0]  acc;
  logic [DATA_W-1:0]  vshift;

  // Memory port.
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [7:0]         mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [7:0]         rdata;

  logic [LIM_W-1:0]   limit_calc;
  logic [DEPTH_W-1:0] depth_clamp;
  logic               hdr_write;
  logic               hdr_ok;
  logic [DEPTH_W-1:0] hdr_cnt;
  logic               is_embed;
  logic               is_byte;
  logic               addr_ok;

  logic [3:0]         room;
  logic [3:0]         n;
  logic [3:0]         shift;
  logic [7:0]         m;
  logic [7:0]         in_bits;
  logic [7:0]         new_byte;
  logic [7:0]         out_bits;
  logic [DATA_W-1:0]  acc_next;
  logic [DATA_W-1:0]  vshift_next;
  logic [6:0]         remaining_next;
  logic [3:0]         bit_sum;
  logic [CUR_W-1:0]   c1;
  logic [CUR_W-1:0]   cursor_byte_next;
  logic [2:0]         cursor_bit_next;

  assign limit_calc  = (32'(image_bytes) < IMG_BYTES) ? image_bytes : LIM_W'(IMG_BYTES);
  assign depth_clamp = (depth_setting > 4'd8) ? 4'd8 : depth_setting;
  assign hdr_write   = (depth_setting != '0) && (limit_calc != '0);
  assign hdr_ok      = (rdata != 8'd0) && ((rdata & (rdata + 8'd1)) == 8'd0);
  assign hdr_cnt     = DEPTH_W'($countones(rdata));
  assign addr_ok     = (32'(item.address) < IMG_BYTES);
  assign is_embed    = (item.cmd == CMD_EMBED_BYTE) || (item.cmd == CMD_EMBED_WORD);
  assign is_byte     = (item.cmd == CMD_EMBED_BYTE) || (item.cmd == CMD_EXTRACT_BYTE);

  // One cover byte of a transfer.
  always_comb begin
    room     = session_depth - {1'b0, cursor_bit};
    n        = (remaining < {3'd0, room}) ? remaining[3:0] : room;
    shift    = room - n;
    m        = ones_mask(n);
    in_bits  = vshift[DATA_W-1 -: 8] >> (4'd8 - n);
    new_byte = (rdata & ~(m << shift)) | (in_bits << shift);
    out_bits = (rdata >> shift) & m;
    acc_next       = (acc << n) | {56'd0, out_bits};
    vshift_next    = vshift << n;
    remaining_next = remaining - {3'd0, n};
    bit_sum        = {1'b0, cursor_bit} + n;
    c1             = cursor_byte + CUR_W'(1);
    if (bit_sum >= session_depth) begin
      cursor_byte_next = (alpha_present && (c1[1:0] == 2'b11)) ? c1 + CUR_W'(1) : c1;
      cursor_bit_next  = 3'd0;
    end else begin
      cursor_byte_next = cursor_byte;
      cursor_bit_next  = bit_sum[2:0];
    end
  end

  always_comb begin
    status.cmd          = item.cmd;
    status.begin_direct = (depth_setting != '0) || (limit_calc == '0);
    status.xfer_go      = (remaining != 7'd0) && (session_depth != '0) &&
                          (cursor_byte < {1'b0, session_limit});
    status.xfer_go_next = (remaining_next != 7'd0) &&
                          (cursor_byte_next < {1'b0, session_limit});
  end

  // Read address follows the command; during a transfer it runs one byte ahead.
  always_comb begin
    case (item.cmd)
      CMD_READ: begin
        mem_raddr = AW'(item.address);
      end
      CMD_BEGIN: begin
        mem_raddr = '0;
      end
      default: begin
        mem_raddr = cmd.xfer_step ? AW'(cursor_byte_next) : AW'(cursor_byte);
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(cursor_byte);
    mem_wdata = new_byte;
    if (cmd.load_wr) begin
      mem_we    = addr_ok;
      mem_waddr = AW'(item.address);
      mem_wdata = item.payload[7:0];
    end else if (cmd.begin_set) begin
      mem_we    = hdr_write;
      mem_waddr = '0;
      mem_wdata = ones_mask(depth_clamp);
    end else if (cmd.xfer_step) begin
      mem_we    = is_embed;
    end
  end

  lse_ram #(
    .WIDTH(8),
    .DEPTH(IMG_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(rdata)
  );

  // Configuration and session registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_setting <= '0;
      alpha_present <= 1'b0;
      image_bytes   <= '0;
      cursor_byte   <= '0;
      cursor_bit    <= '0;
      session_depth <= '0;
      session_limit <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEPTH_SETTING: depth_setting <= cfg_data[DEPTH_W-1:0];
          REG_ALPHA_PRESENT: alpha_present <= cfg_data[0];
          REG_IMAGE_BYTES:   image_bytes   <= cfg_data[LIM_W-1:0];
          default: begin
            image_bytes <= image_bytes;
          end
        endcase
      end
      if (cmd.begin_set) begin
        session_depth <= depth_clamp;
        session_limit <= limit_calc;
        cursor_byte   <= CUR_W'(1);
        cursor_bit    <= 3'd0;
      end else if (cmd.begin_detect) begin
        session_depth <= hdr_ok ? hdr_cnt : '0;
        session_limit <= hdr_ok ? limit_calc : '0;
        cursor_byte   <= CUR_W'(1);
        cursor_bit    <= 3'd0;
      end else if (cmd.xfer_step) begin
        cursor_byte <= cursor_byte_next;
        cursor_bit  <= cursor_bit_next;
      end
    end
  end

  // Item working registers and the result register.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= req_item;
    end
    if (cmd.begin_set) begin
      begin_ok <= (depth_clamp != '0) && (limit_calc != '0);
    end else if (cmd.begin_detect) begin
      begin_ok <= hdr_ok;
    end
    if (cmd.xfer_init) begin
      remaining <= is_byte ? 7'd8 : 7'd64;
      vshift    <= is_byte ? {item.payload[7:0], 56'd0} : item.payload;
      acc       <= '0;
    end else if (cmd.read_capture) begin
      acc <= {56'd0, rdata};
    end else if (cmd.xfer_step) begin
      remaining <= remaining_next;
      vshift    <= vshift_next;
      acc       <= acc_next;
    end
    if (cmd.fin) begin
      rsp_item.active_depth <= session_depth;
      case (item.cmd)
        CMD_LOAD: begin
          rsp_item.result_data <= '0;
          rsp_item.complete    <= addr_ok;
        end
        CMD_READ: begin
          rsp_item.result_data <= addr_ok ? acc : '0;
          rsp_item.complete    <= addr_ok;
        end
        CMD_BEGIN: begin
          rsp_item.result_data <= '0;
          rsp_item.complete    <= begin_ok;
        end
        CMD_EMBED_BYTE, CMD_EMBED_WORD: begin
          rsp_item.result_data <= '0;
          rsp_item.complete    <= (remaining == 7'd0);
        end
        CMD_EXTRACT_BYTE, CMD_EXTRACT_WORD: begin
          rsp_item.result_data <= acc << remaining;
          rsp_item.complete    <= (remaining == 7'd0);
        end
        default: begin
          rsp_item.result_data <= '0;
          rsp_item.complete    <= 1'b0;
        end
      endcase
    end
  end

endmodule
